### src/prb_pkg.sv
package prb_pkg;

  localparam int unsigned WindowSlots = 16;
  localparam int unsigned MaxPayload  = 2048;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned SeqHiPos    = 2;
  localparam int unsigned SeqLoPos    = 3;

  localparam int unsigned SlotW   = $clog2(WindowSlots);
  localparam int unsigned OffW    = $clog2(MaxPayload);
  localparam int unsigned PosW    = $clog2(HeaderBytes + MaxPayload + 2);
  localparam int unsigned LenW    = OffW + 1;
  localparam int unsigned AddrW   = SlotW + OffW;
  localparam int unsigned QDepth  = 2;

  typedef enum logic [1:0] {
    OpByte  = 2'd0,
    OpDrain = 2'd1,
    OpFlush = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic {
    KindData = 1'b0,
    KindDrop = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] out_seq;
  } out_t;

  // Command from front to back.
  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic             wr_en;
    logic [OffW-1:0]  wr_off;
    logic             hdr;     // header verdict point
    logic             last;
    logic             len_ok;  // payload length in range
    logic [LenW-1:0]  plen;
    logic [15:0]      seq;
  } cmd_t;

endpackage

### src/packet_reorder_buffer.sv
// Packet reorder buffer.
// Input channel (in_valid_i/in_ready_o, in_data_i): one transfer per packet
// byte, drain tick or flush. Output channel (out_valid_o/out_ready_i,
// out_data_o): payload bytes in sequence order or drop reports.
// cfg_we_i/cfg_wdata_i write the start threshold (reset value 5).
// A front stage tracks byte position and assembles the sequence number,
// a two-entry queue decouples it from the back stage, which owns the
// window slots and the 32 KiB payload memory.
// Packet bytes and flushes: one per cycle while the back stage does not stall.
// A drain tick that emits a byte stalls the back stage until its registered
// memory read is done. Drop reports pass the output register; payload bytes
// pass the memory read register and then the output register, plus queue wait.
// Reset empties all slots and state; memory contents are not cleared.
// When the receiver stalls, the back stage holds its result and stops,
// the queue fills and in_ready_o drops.
module packet_reorder_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  prb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output prb_pkg::out_t out_data_o
);

  prb_pkg::cmd_t fcmd, bcmd;
  logic          fvalid, qready, bvalid, bready;

  prb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(fvalid), .cmd_ready_i(qready), .cmd_o(fcmd)
  );

  prb_queue u_queue (
    .clk_i, .rst_ni, .push_i(fvalid), .ready_o(qready), .data_i(fcmd),
    .valid_o(bvalid), .pop_i(bready), .data_o(bcmd)
  );

  prb_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_i(bvalid), .cmd_ready_o(bready), .cmd_i(bcmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

### src/prb_front.sv
module prb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  prb_pkg::in_t   in_data_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output prb_pkg::cmd_t  cmd_o
);

  logic [prb_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]              seq_q, seq_d;
  logic [prb_pkg::PosW:0]   n;
  logic                     fire;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign fire        = in_valid_i && cmd_ready_i;
  assign n           = {1'b0, pos_q} + 1'b1;

  always_comb begin
    seq_d = seq_q;
    if (pos_q == prb_pkg::PosW'(prb_pkg::SeqHiPos)) seq_d[15:8] = in_data_i.in_byte;
    if (pos_q == prb_pkg::PosW'(prb_pkg::SeqLoPos)) seq_d[7:0]  = in_data_i.in_byte;
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = prb_pkg::op_e'(in_data_i.op);
    cmd_o.data   = in_data_i.in_byte;
    cmd_o.last   = in_data_i.in_last;
    cmd_o.seq    = seq_d;
    cmd_o.hdr    = (pos_q == prb_pkg::PosW'(prb_pkg::HeaderBytes - 1));
    cmd_o.wr_en  = (pos_q >= prb_pkg::PosW'(prb_pkg::HeaderBytes)) &&
                   (pos_q < prb_pkg::PosW'(prb_pkg::HeaderBytes + prb_pkg::MaxPayload));
    cmd_o.wr_off = prb_pkg::OffW'(pos_q - prb_pkg::PosW'(prb_pkg::HeaderBytes));
    cmd_o.len_ok = (n > (prb_pkg::PosW+1)'(prb_pkg::HeaderBytes)) &&
                   (n <= (prb_pkg::PosW+1)'(prb_pkg::HeaderBytes + prb_pkg::MaxPayload));
    cmd_o.plen   = prb_pkg::LenW'(n - (prb_pkg::PosW+1)'(prb_pkg::HeaderBytes));
  end

  always_comb begin
    pos_d = pos_q;
    if (fire && in_data_i.op == prb_pkg::OpByte) begin
      if (in_data_i.in_last) begin
        pos_d = '0;
      end else if (pos_q <= prb_pkg::PosW'(prb_pkg::HeaderBytes + prb_pkg::MaxPayload)) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      seq_q <= '0;
    end else if (fire && in_data_i.op == prb_pkg::OpByte) begin
      pos_q <= pos_d;
      seq_q <= in_data_i.in_last ? 16'd0 : seq_d;
    end
  end

endmodule

### src/prb_queue.sv
module prb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           ready_o,
  input  prb_pkg::cmd_t  data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output prb_pkg::cmd_t  data_o
);

  localparam int unsigned PtrW = $clog2(prb_pkg::QDepth);

  prb_pkg::cmd_t       mem_q [prb_pkg::QDepth];
  logic [PtrW-1:0]     wp_q, rp_q;
  logic [PtrW:0]       cnt_q;
  logic                do_push, do_pop;

  assign ready_o = cnt_q != (PtrW+1)'(prb_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

### src/prb_back.sv
module prb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  prb_pkg::cmd_t  cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output prb_pkg::out_t  out_data_o
);

  localparam int unsigned SlotW = prb_pkg::SlotW;
  localparam int unsigned OffW  = prb_pkg::OffW;
  localparam int unsigned LenW  = prb_pkg::LenW;

  logic [7:0]  mem_q [2**prb_pkg::AddrW];
  logic [7:0]  rd_q;

  logic [prb_pkg::WindowSlots-1:0] vld_q, vld_d;
  logic [LenW-1:0] len_q [prb_pkg::WindowSlots];
  logic [15:0]     tag_q [prb_pkg::WindowSlots];

  logic [7:0]      thr_q;
  logic [15:0]     exp_q, exp_d, min_q, min_d;
  logic            fixed_q, fixed_d, ok_q, ok_d;
  logic [7:0]      seen_q, seen_d;
  logic [OffW-1:0] doff_q, doff_d;

  // drain: read issued, result shows next cycle
  logic            pend_q;
  logic            pend_last_q;
  logic [15:0]     pend_seq_q;

  logic            ov_q, ov_d;
  prb_pkg::out_t   od_q, od_d;

  logic [SlotW-1:0] rs, es;
  logic             inwin, go, keep, can_drain, fin;
  logic             ok_v, evict;
  logic [LenW-1:0]  elen;
  logic             wr_store, tag_wr;
  logic [prb_pkg::AddrW-1:0] waddr;
  logic [15:0]      seq_gap;

  assign rs      = cmd_i.seq[SlotW-1:0];
  assign es      = exp_q[SlotW-1:0];
  assign seq_gap = cmd_i.seq - exp_q;
  assign inwin   = seq_gap < 16'(prb_pkg::WindowSlots);
  assign elen    = len_q[es];

  // stall while an output waits or a drain read is in flight
  assign cmd_ready_o = !pend_q && (!ov_q || out_ready_i);
  assign go          = cmd_valid_i && cmd_ready_o;

  // header verdict, valid for the whole transfer
  always_comb begin
    ok_v  = ok_q;
    evict = 1'b0;
    if (cmd_i.op == prb_pkg::OpByte && cmd_i.hdr) begin
      if (!fixed_q) begin
        ok_v = !vld_q[rs];
      end else if (!inwin || (vld_q[rs] && tag_q[rs] == cmd_i.seq)) begin
        ok_v = 1'b0;
      end else begin
        ok_v  = 1'b1;
        evict = 1'b1;
      end
    end
  end

  assign can_drain = fixed_q && vld_q[es] && tag_q[es] == exp_q;
  assign fin       = ({1'b0, doff_q} + 1'b1) >= elen;
  assign keep      = ok_v && cmd_i.len_ok && (!fixed_q || inwin);
  assign waddr     = {rs, cmd_i.wr_off};
  assign wr_store  = go && cmd_i.op == prb_pkg::OpByte && cmd_i.wr_en && ok_v;
  assign tag_wr    = go && cmd_i.op == prb_pkg::OpByte && cmd_i.last && keep;

  always_comb begin
    vld_d   = vld_q;
    exp_d   = exp_q;
    min_d   = min_q;
    fixed_d = fixed_q;
    ok_d    = ok_q;
    seen_d  = seen_q;
    doff_d  = doff_q;
    ov_d    = ov_q && !out_ready_i;
    od_d    = od_q;
    if (pend_q) begin
      ov_d          = 1'b1;
      od_d.out_kind = prb_pkg::KindData;
      od_d.out_byte = rd_q;
      od_d.out_last = pend_last_q;
      od_d.out_seq  = pend_seq_q;
    end
    if (go) begin
      case (cmd_i.op)
        prb_pkg::OpByte: begin
          if (cmd_i.hdr) begin
            ok_d = ok_v;
            if (evict) vld_d[rs] = 1'b0;
          end
          if (cmd_i.last) begin
            if (keep) begin
              vld_d[rs] = 1'b1;
              if (!fixed_q) begin
                if (seen_q != 8'hff) seen_d = seen_q + 1'b1;
                if (cmd_i.seq < min_q) min_d = cmd_i.seq;
                if (seen_d >= thr_q) begin
                  exp_d   = min_d;
                  fixed_d = 1'b1;
                end
              end
            end else begin
              ov_d          = 1'b1;
              od_d.out_kind = prb_pkg::KindDrop;
              od_d.out_byte = '0;
              od_d.out_last = 1'b0;
              od_d.out_seq  = cmd_i.seq;
            end
            ok_d = 1'b0;
          end
        end
        prb_pkg::OpDrain: begin
          if (can_drain) begin
            if (fin) begin
              vld_d[es] = 1'b0;
              doff_d    = '0;
              exp_d     = exp_q + 1'b1;
            end else begin
              doff_d = doff_q + 1'b1;
            end
          end
        end
        prb_pkg::OpFlush: begin
          if (!fixed_q && seen_q != '0) begin
            exp_d   = min_q;
            fixed_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_store) mem_q[waddr] <= cmd_i.data;
    rd_q <= mem_q[{es, doff_q}];
    if (tag_wr) begin
      tag_q[rs] <= cmd_i.seq;
      len_q[rs] <= cmd_i.plen;
    end
    od_q <= od_d;
    if (go && cmd_i.op == prb_pkg::OpDrain && can_drain) begin
      pend_last_q <= fin;
      pend_seq_q  <= exp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 8'd5;
      vld_q   <= '0;
      exp_q   <= '0;
      min_q   <= 16'hffff;
      fixed_q <= 1'b0;
      ok_q    <= 1'b0;
      seen_q  <= '0;
      doff_q  <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      vld_q   <= vld_d;
      exp_q   <= exp_d;
      min_q   <= min_d;
      fixed_q <= fixed_d;
      ok_q    <= ok_d;
      seen_q  <= seen_d;
      doff_q  <= doff_d;
      pend_q  <= go && cmd_i.op == prb_pkg::OpDrain && can_drain;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

### src/prb_checker.sv
module prb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input prb_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  a_drop_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind == prb_pkg::KindDrop |->
      out_data_o.out_byte == 8'd0 && !out_data_o.out_last)
    else $error("bad drop report");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.out_kind == prb_pkg::KindData &&
    !out_data_o.out_last ##1 out_valid_o && out_data_o.out_kind == prb_pkg::KindData
      |-> out_data_o.out_seq == $past(out_data_o.out_seq))
    else $error("payload sequence changed mid packet");

endmodule

bind packet_reorder_buffer prb_checker u_prb_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_data_o
);
